[sv/sc_pkg.sv]
// ============================================================================
// sc_pkg
// Shared types, constants and index tables for the shuffled Salsa20 core.
// ============================================================================
`default_nettype none

package sc_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = 16;
    localparam int NUM_FIELDS = 8;
    localparam int FIELD_W    = 64;
    localparam int RC_W       = 4;
    localparam int PAIRS_W    = 4;

    localparam logic [RC_W-1:0] RC_RESET = 4'd8;
    localparam int DEF_MAX_DOUBLE_ROUNDS = 4;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [NUM_WORDS-1:0] block_t;

    typedef struct packed {
        logic               valid;
        logic [PAIRS_W-1:0] pairs;
    } ctl_t;

    // Working position of input word i: i*5 mod 16
    localparam logic [3:0] SHUF [NUM_WORDS] =
        '{4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
          4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11};

    // Quarter-round positions a, b, c, d; first index 0 = column, 1 = row
    localparam logic [3:0] QR_POS [2][4][4] = '{
        '{'{4'd0,  4'd4,  4'd8,  4'd12},
          '{4'd5,  4'd9,  4'd13, 4'd1},
          '{4'd10, 4'd14, 4'd2,  4'd6},
          '{4'd15, 4'd3,  4'd7,  4'd11}},
        '{'{4'd0,  4'd1,  4'd2,  4'd3},
          '{4'd5,  4'd6,  4'd7,  4'd4},
          '{4'd10, 4'd11, 4'd8,  4'd9},
          '{4'd15, 4'd12, 4'd13, 4'd14}}
    };

    localparam int ROT [4] = '{7, 9, 13, 18};

    // Bit 2: position is written in this step; bits 1:0: quarter that writes it
    function automatic logic [2:0] tgt_lookup(input int row, input int step, input int pos);
        logic [2:0] r;
        int         slot;
        r    = 3'b000;
        slot = (step + 1) & 3;
        for (int q = 0; q < 4; q++) begin
            if (QR_POS[row][q][slot] == 4'(pos)) begin
                r = {1'b1, 2'(q)};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/sc_step.sv]
// ============================================================================
// sc_step
// One pipeline stage: one add-rotate-xor step of all four quarter rounds of
// a column or row round, skipped when the item runs fewer double rounds.
// ============================================================================
`default_nettype none

module sc_step #(
    parameter int DR_INDEX = 0,
    parameter int ROW      = 0,
    parameter int STEP     = 0
) (
    input  wire             clk,
    input  wire             rst_n,
    input  sc_pkg::ctl_t    ctl_i,
    input  sc_pkg::block_t  work_i,
    input  sc_pkg::block_t  src_i,
    output sc_pkg::ctl_t    ctl_o,
    output sc_pkg::block_t  work_o,
    output sc_pkg::block_t  src_o
);

    localparam int X_SLOT  = STEP;
    localparam int Y_SLOT  = (STEP + 3) & 3;
    localparam int T_SLOT  = (STEP + 1) & 3;
    localparam int ROT_AMT = sc_pkg::ROT[STEP];

    sc_pkg::ctl_t   ctl_reg;
    sc_pkg::block_t work_reg;
    sc_pkg::block_t src_reg;
    sc_pkg::block_t work_next;
    sc_pkg::word_t  upd [4];
    logic           active;

    assign active = ctl_i.pairs > sc_pkg::PAIRS_W'(DR_INDEX);

    genvar q, p;
    generate
        for (q = 0; q < 4; q++) begin : g_quarter
            sc_pkg::word_t s;
            sc_pkg::word_t r;
            assign s = work_i[sc_pkg::QR_POS[ROW][q][X_SLOT]]
                     + work_i[sc_pkg::QR_POS[ROW][q][Y_SLOT]];
            assign r = (s << ROT_AMT) | (s >> (sc_pkg::WORD_W - ROT_AMT));
            assign upd[q] = work_i[sc_pkg::QR_POS[ROW][q][T_SLOT]] ^ r;
        end

        for (p = 0; p < sc_pkg::NUM_WORDS; p++) begin : g_pos
            localparam logic [2:0] HIT = sc_pkg::tgt_lookup(ROW, STEP, p);
            if (HIT[2]) begin : g_hit
                assign work_next[p] = active ? upd[HIT[1:0]] : work_i[p];
            end
            else begin : g_keep
                assign work_next[p] = work_i[p];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        src_reg  <= src_i;
    end

    assign ctl_o  = ctl_reg;
    assign work_o = work_reg;
    assign src_o  = src_reg;

endmodule

`default_nettype wire

[sv/salsa20_core_shuffled_top.sv]
// ============================================================================
// salsa20_core_shuffled_top
// Fully unrolled, pipelined Salsa20 core over a shuffled working layout.
// ============================================================================
// Usage:
//   Input: drive the sixteen words on in_words_* and raise start; the item is
//   taken at any rising edge with start high and busy low. busy stays low, so
//   one item can enter every cycle.
//   Output: done is high for one cycle with the result on out_words_*. The
//   receiver cannot hold results off; sample them on that cycle.
//   Pipeline: one register stage per add-rotate-xor step of the four quarter
//   rounds, plus one input and one output register.
//   Throughput: one item per cycle.
//   Configuration: cfg_we with cfg_wdata writes round_count; write only while
//   no item is in flight. Each item keeps the double-round count it entered
//   with, saturated at MAX_DOUBLE_ROUNDS.
//   Reset: rst_n clears all valid bits and sets round_count to 8.
// ============================================================================
`default_nettype none

module salsa20_core_shuffled_top #(
    parameter int MAX_DOUBLE_ROUNDS = sc_pkg::DEF_MAX_DOUBLE_ROUNDS
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_we,
    input  wire [sc_pkg::RC_W-1:0]     cfg_wdata,
    input  wire                        start,
    output logic                       busy,
    input  wire [sc_pkg::FIELD_W-1:0]  in_words_0_1,
    input  wire [sc_pkg::FIELD_W-1:0]  in_words_2_3,
    input  wire [sc_pkg::FIELD_W-1:0]  in_words_4_5,
    input  wire [sc_pkg::FIELD_W-1:0]  in_words_6_7,
    input  wire [sc_pkg::FIELD_W-1:0]  in_words_8_9,
    input  wire [sc_pkg::FIELD_W-1:0]  in_words_10_11,
    input  wire [sc_pkg::FIELD_W-1:0]  in_words_12_13,
    input  wire [sc_pkg::FIELD_W-1:0]  in_words_14_15,
    output logic                       done,
    output logic [sc_pkg::FIELD_W-1:0] out_words_0_1,
    output logic [sc_pkg::FIELD_W-1:0] out_words_2_3,
    output logic [sc_pkg::FIELD_W-1:0] out_words_4_5,
    output logic [sc_pkg::FIELD_W-1:0] out_words_6_7,
    output logic [sc_pkg::FIELD_W-1:0] out_words_8_9,
    output logic [sc_pkg::FIELD_W-1:0] out_words_10_11,
    output logic [sc_pkg::FIELD_W-1:0] out_words_12_13,
    output logic [sc_pkg::FIELD_W-1:0] out_words_14_15
);

    localparam int N_STEPS = 8 * MAX_DOUBLE_ROUNDS;
    localparam int LAT     = N_STEPS + 1;
    localparam logic [sc_pkg::RC_W:0] MAX_DR_EXT = (sc_pkg::RC_W + 1)'(MAX_DOUBLE_ROUNDS);

    logic [sc_pkg::RC_W-1:0] round_count_reg;
    logic [sc_pkg::RC_W:0]   rc_half;
    logic [sc_pkg::RC_W:0]   pairs_sat;
    logic                    accept;
    sc_pkg::block_t          src_in;
    sc_pkg::block_t          work_in;
    sc_pkg::block_t          sum_next;

    sc_pkg::ctl_t   ctl_chain  [N_STEPS+1];
    sc_pkg::block_t work_chain [N_STEPS+1];
    sc_pkg::block_t src_chain  [N_STEPS+1];

    sc_pkg::ctl_t   ctl0_reg;
    sc_pkg::block_t work0_reg;
    sc_pkg::block_t src0_reg;
    logic           done_reg;
    sc_pkg::block_t out_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // round count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= sc_pkg::RC_RESET;
        end
        else if (cfg_we)
        begin
            round_count_reg <= cfg_wdata;
        end
    end

    assign rc_half   = ((sc_pkg::RC_W + 1)'(round_count_reg) + 1'b1) >> 1;
    assign pairs_sat = (rc_half > MAX_DR_EXT) ? MAX_DR_EXT : rc_half;

    // unpack and shuffle
    assign src_in = {in_words_14_15, in_words_12_13, in_words_10_11, in_words_8_9,
                     in_words_6_7, in_words_4_5, in_words_2_3, in_words_0_1};

    genvar i;
    generate
        for (i = 0; i < sc_pkg::NUM_WORDS; i++) begin : g_shuf
            assign work_in[sc_pkg::SHUF[i]] = src_in[i];
            assign sum_next[i] = src_chain[N_STEPS][i] + work_chain[N_STEPS][sc_pkg::SHUF[i]];
        end
    endgenerate

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else
        begin
            ctl0_reg.valid <= accept;
            ctl0_reg.pairs <= sc_pkg::PAIRS_W'(pairs_sat);
        end
    end

    always_ff @(posedge clk)
    begin
        work0_reg <= work_in;
        src0_reg  <= src_in;
    end

    assign ctl_chain[0]  = ctl0_reg;
    assign work_chain[0] = work0_reg;
    assign src_chain[0]  = src0_reg;

    // round pipeline
    genvar d, h, s;
    generate
        for (d = 0; d < MAX_DOUBLE_ROUNDS; d++) begin : g_dr
            for (h = 0; h < 2; h++) begin : g_half
                for (s = 0; s < 4; s++) begin : g_step
                    localparam int N = d * 8 + h * 4 + s;
                    sc_step #(
                        .DR_INDEX (d),
                        .ROW      (h),
                        .STEP     (s)
                    ) u_step (
                        .clk    (clk),
                        .rst_n  (rst_n),
                        .ctl_i  (ctl_chain[N]),
                        .work_i (work_chain[N]),
                        .src_i  (src_chain[N]),
                        .ctl_o  (ctl_chain[N+1]),
                        .work_o (work_chain[N+1]),
                        .src_o  (src_chain[N+1])
                    );
                end
            end
        end
    endgenerate

    // feed-forward add and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_chain[N_STEPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= sum_next;
    end

    assign done            = done_reg;
    assign out_words_0_1   = {out_reg[1],  out_reg[0]};
    assign out_words_2_3   = {out_reg[3],  out_reg[2]};
    assign out_words_4_5   = {out_reg[5],  out_reg[4]};
    assign out_words_6_7   = {out_reg[7],  out_reg[6]};
    assign out_words_8_9   = {out_reg[9],  out_reg[8]};
    assign out_words_10_11 = {out_reg[11], out_reg[10]};
    assign out_words_12_13 = {out_reg[13], out_reg[12]};
    assign out_words_14_15 = {out_reg[15], out_reg[14]};

    // every accepted item comes out after the fixed latency
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LAT + 1) done)
        else $error("item lost in round pipeline");

    // nothing comes out that was not taken in
    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT + 1))
        else $error("result without accepted item");

    // double-round count is saturated on entry
    a_pairs_sat : assert property (@(posedge clk) disable iff (!rst_n)
        ctl_chain[0].valid |-> (ctl_chain[0].pairs <= sc_pkg::PAIRS_W'(MAX_DOUBLE_ROUNDS)))
        else $error("double-round count above pipeline depth");

    // zero rounds leave the working block untouched (checked on word 1)
    a_zero_rounds : assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_chain[N_STEPS].valid && (ctl_chain[N_STEPS].pairs == '0))
        |-> (work_chain[N_STEPS][sc_pkg::SHUF[1]] == src_chain[N_STEPS][1]))
        else $error("words mixed with zero rounds");

endmodule

`default_nettype wire
